// File: rtl/core/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared types and codes for the sorted score table
// operation, status and cell command codes, slot and cell control structs
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

    localparam int ID_W     = 16;
    localparam int SCORE_W  = 32;
    localparam int RANK_W   = 4;
    localparam int CNT_W    = 5;
    localparam int MAX_DUMP = 16;

    // operation codes; any code with bit 1 set dumps the table
    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_UPDATE   = 2'd1;
    localparam logic [1:0] OP_DUMP     = 2'd2;
    localparam logic [1:0] OP_DUMP_ALT = 2'd3;
    localparam int         OP_DUMP_BIT = 1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_ROTATE
    } cell_cmd_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_REINSERT,
        FSM_DUMP
    } fsm_state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } slot_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [ID_W-1:0]    key_id;
        logic [SCORE_W-1:0] key_score;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/sst_cell.sv
// ----------------------------------------------------------------------------
// sst_cell: one slot of the sorted chain
// holds one (id, score) pair, shifts right on insert, left on remove/rotate
// ----------------------------------------------------------------------------
`default_nettype none

module sst_cell
    import sst_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,
    input  wire logic       tail,
    input  wire slot_t      left_slot,
    input  wire logic       left_ge,
    input  wire slot_t      right_slot,
    input  wire slot_t      head_slot,
    input  wire logic       after_in,
    output slot_t           slot,
    output logic            ge,
    output logic            after_out,
    output logic            take_new
);

    slot_t slot_reg;
    slot_t slot_next;

    assign slot = slot_reg;

    // at or past the insert position: empty, or strictly lower score
    assign ge        = !occupied || (slot_reg.score < ctrl.key_score);
    assign take_new  = ge && !left_ge;
    // at or past the first slot holding the searched id
    assign after_out = after_in || (occupied && (slot_reg.id == ctrl.key_id));

    always_comb
    begin
        slot_next = slot_reg;
        case (ctrl.cmd)
            CMD_INSERT:
            begin
                if (left_ge)
                begin
                    slot_next = left_slot;
                end
                else if (ge)
                begin
                    slot_next.id    = ctrl.key_id;
                    slot_next.score = ctrl.key_score;
                end
            end
            CMD_REMOVE:
            begin
                if (after_out)
                begin
                    slot_next = right_slot;
                end
            end
            CMD_ROTATE:
            begin
                if (occupied)
                begin
                    slot_next = tail ? head_slot : right_slot;
                end
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/sorted_score_table_core.sv
// ----------------------------------------------------------------------------
// sorted_score_table_core: table of (id, score) entries in descending order
// chain of slot cells with a small sequencer and a registered result port
// ----------------------------------------------------------------------------
// usage
//   s_* carries requests: s_tuser = operation (0 insert, 1 update, 2/3 dump),
//   s_tdata = entry id and score. m_* carries results: m_tuser = status,
//   m_tdata = rank, id, score and entry count, m_tlast on the final result.
// sequence
//   insert: the chain shifts and the result register loads at the accepting
//   edge, so the result is valid in the next cycle and a new request can
//   follow once the result slot frees. update: the accepting edge pulls the
//   entry out of the chain or, if the id is not found, loads ST_NOT_FOUND; the
//   next edge puts it back and loads the result. dump: an empty table loads
//   ST_EMPTY at the accepting edge; else that edge starts the sequencer, then
//   one held entry per cycle while the result slot is free; the chain rotates
//   through the occupied slots and slot 0 feeds the result port; with more
//   than 16 entries the rotation finishes without results.
// reset
//   the entry count clears and the table is empty; slot contents are not
//   cleared, only slots below the count are ever read.
// back-pressure
//   a single result register parts the two sides; when it holds a result
//   and m_tready is low the chain waits and s_tready stays low till it frees.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_score_table_core
    import sst_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // entry_id[15:0], score[47:16]
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // rank[3:0], out_id[19:4], out_score[51:20],
                                        // entry_count[56:52], zero fill above
    output logic [1:0]       m_tuser,   // status[1:0]
    output logic             m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > CNT_W) ? CW + 1 : CNT_W + 1;

    // request fields
    logic [ID_W-1:0]    in_id;
    logic [SCORE_W-1:0] in_score;
    logic [1:0]         in_op;
    logic               s_accept;

    assign in_id    = s_tdata[ID_W-1:0];
    assign in_score = s_tdata[ID_W +: SCORE_W];
    assign in_op    = s_tuser;

    // control state
    fsm_state_t  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] step_reg, step_next;

    // pending entry of an update between removal and reinsertion
    logic [ID_W-1:0]    pend_id_reg, pend_id_next;
    logic [SCORE_W-1:0] pend_score_reg, pend_score_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    status_t            r_status_reg, r_status_next;
    logic [RANK_W-1:0]  r_rank_reg, r_rank_next;
    logic [ID_W-1:0]    r_id_reg, r_id_next;
    logic [SCORE_W-1:0] r_score_reg, r_score_next;
    logic [CNT_W-1:0]   r_count_reg, r_count_next;
    logic               r_last_reg, r_last_next;
    logic               load;
    logic               out_free;

    // chain
    cell_ctrl_t ctrl;
    cell_cmd_t  chain_cmd;
    slot_t      cell_slot  [CAPACITY];
    slot_t      left_slot  [CAPACITY];
    slot_t      right_slot [CAPACITY];
    logic       cell_ge    [CAPACITY];
    logic       left_ge    [CAPACITY];
    logic       cell_after [CAPACITY];
    logic       after_in   [CAPACITY];
    logic       cell_take  [CAPACITY];
    logic       cell_occ   [CAPACITY];
    logic       cell_tail  [CAPACITY];

    logic [RANK_W-1:0] ins_rank;
    logic              found;
    logic              full;

    // dump bookkeeping
    logic [XW-1:0] step_x;
    logic [XW-1:0] cnt_x;
    logic [XW-1:0] dump_n;
    logic          dump_emit;
    logic          dump_last;
    logic          dump_done;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == FSM_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    // the reinsert step searches with the pending entry
    assign ctrl = '{
        cmd:       chain_cmd,
        key_id:    (state_reg == FSM_REINSERT) ? pend_id_reg : in_id,
        key_score: (state_reg == FSM_REINSERT) ? pend_score_reg : in_score
    };

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(gi);

            assign cell_occ[gi]  = IDX < count_reg;
            assign cell_tail[gi] = (IDX + CW'(1)) == count_reg;

            if (gi == 0)
            begin : g_first
                assign left_slot[gi] = cell_slot[gi];
                assign left_ge[gi]   = 1'b0;
                assign after_in[gi]  = 1'b0;
            end
            else
            begin : g_inner
                assign left_slot[gi] = cell_slot[gi-1];
                assign left_ge[gi]   = cell_ge[gi-1];
                assign after_in[gi]  = cell_after[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_slot[gi] = cell_slot[0];
            end
            else
            begin : g_mid
                assign right_slot[gi] = cell_slot[gi+1];
            end

            sst_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (cell_occ[gi]),
                .tail       (cell_tail[gi]),
                .left_slot  (left_slot[gi]),
                .left_ge    (left_ge[gi]),
                .right_slot (right_slot[gi]),
                .head_slot  (cell_slot[0]),
                .after_in   (after_in[gi]),
                .slot       (cell_slot[gi]),
                .ge         (cell_ge[gi]),
                .after_out  (cell_after[gi]),
                .take_new   (cell_take[gi])
            );
        end
    endgenerate

    // insert position from the one-hot take flags
    always_comb
    begin
        ins_rank = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_take[i])
            begin
                ins_rank = ins_rank | RANK_W'(i);
            end
        end
    end

    assign found = cell_after[CAPACITY-1];
    assign full  = count_reg == CW'(CAPACITY);

    assign step_x    = XW'(step_reg);
    assign cnt_x     = XW'(count_reg);
    assign dump_n    = (cnt_x < XW'(MAX_DUMP)) ? cnt_x : XW'(MAX_DUMP);
    assign dump_emit = step_x < dump_n;
    assign dump_last = (step_x + XW'(1)) == dump_n;
    assign dump_done = (step_x + XW'(1)) == cnt_x;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        pend_id_next    = pend_id_reg;
        pend_score_next = pend_score_reg;
        chain_cmd       = CMD_HOLD;
        load            = 1'b0;
        r_status_next   = ST_OK;
        r_rank_next     = '0;
        r_id_next       = in_id;
        r_score_next    = in_score;
        r_count_next    = CNT_W'(count_reg);
        r_last_next     = 1'b1;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (s_accept)
                begin
                    if (in_op[OP_DUMP_BIT])
                    begin
                        if (count_reg == '0)
                        begin
                            load          = 1'b1;
                            r_status_next = ST_EMPTY;
                            r_id_next     = '0;
                            r_score_next  = '0;
                            r_count_next  = '0;
                        end
                        else
                        begin
                            step_next  = '0;
                            state_next = FSM_DUMP;
                        end
                    end
                    else if (in_op == OP_INSERT)
                    begin
                        load = 1'b1;
                        if (full)
                        begin
                            r_status_next = ST_FULL;
                        end
                        else
                        begin
                            chain_cmd    = CMD_INSERT;
                            count_next   = count_reg + CW'(1);
                            r_rank_next  = ins_rank;
                            r_count_next = CNT_W'(count_reg + CW'(1));
                        end
                    end
                    else
                    begin
                        // update: pull the entry out, put it back next cycle; else report not found
                        chain_cmd = CMD_REMOVE;
                        if (found)
                        begin
                            count_next      = count_reg - CW'(1);
                            pend_id_next    = in_id;
                            pend_score_next = in_score;
                            state_next      = FSM_REINSERT;
                        end
                        else
                        begin
                            load          = 1'b1;
                            r_status_next = ST_NOT_FOUND;
                        end
                    end
                end
            end
            FSM_REINSERT:
            begin
                if (out_free)
                begin
                    chain_cmd    = CMD_INSERT;
                    count_next   = count_reg + CW'(1);
                    load         = 1'b1;
                    r_rank_next  = ins_rank;
                    r_id_next    = pend_id_reg;
                    r_score_next = pend_score_reg;
                    r_count_next = CNT_W'(count_reg + CW'(1));
                    state_next   = FSM_IDLE;
                end
            end
            FSM_DUMP:
            begin
                if (out_free)
                begin
                    chain_cmd    = CMD_ROTATE;
                    load         = dump_emit;
                    r_rank_next  = RANK_W'(step_reg);
                    r_id_next    = cell_slot[0].id;
                    r_score_next = cell_slot[0].score;
                    r_last_next  = dump_last;
                    step_next    = step_reg + CW'(1);
                    if (dump_done)
                    begin
                        state_next = FSM_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg    <= pend_id_next;
        pend_score_reg <= pend_score_next;
        if (load)
        begin
            r_status_reg <= r_status_next;
            r_rank_reg   <= r_rank_next;
            r_id_reg     <= r_id_next;
            r_score_reg  <= r_score_next;
            r_count_reg  <= r_count_next;
            r_last_reg   <= r_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = r_status_reg;
    assign m_tlast  = r_last_reg;
    assign m_tdata  = {7'b0, r_count_reg, r_score_reg, r_id_reg, r_rank_reg};

endmodule

`default_nettype wire
